[hdl/nmtb_pkg.sv]
// ----------------------------------------------------------------------------
// nmtb_pkg
// Shared types and constants for the tanh neuron with backprop training.
// ----------------------------------------------------------------------------
package nmtb_pkg;

  localparam logic [2:0] MODE_FWD  = 3'd0;
  localparam logic [2:0] MODE_OGRD = 3'd1;
  localparam logic [2:0] MODE_HGRD = 3'd2;
  localparam logic [2:0] MODE_UPD  = 3'd3;
  localparam logic [2:0] MODE_LOAD = 3'd4;

  localparam logic [1:0] KIND_OUT  = 2'd0;
  localparam logic [1:0] KIND_GRAD = 2'd1;
  localparam logic [1:0] KIND_WGT  = 2'd2;

  localparam logic [0:0] CFG_LEARN_RATE = 1'd0;
  localparam logic [0:0] CFG_MOMENTUM   = 1'd1;

  // Datapath operations, one per controller step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_FWD_MAC,   // acc += value * weight (weight from RAM read data)
    OP_FWD_END,   // table lookup of acc, clear acc
    OP_HGRD_MAC,  // acc += out_weight * value
    OP_DERIV,     // deriv = 4096 - out*out/4096
    OP_OGRD_MUL,  // grad = (value - out) * deriv / 4096
    OP_HGRD_MUL,  // full product acc * deriv
    OP_HGRD_FIN,  // grad = product / 2^24, saturated
    OP_UPD_P1,    // p1 = eta * value
    OP_UPD_P2,    // p1 * grad, p2 = alpha * olddelta
    OP_UPD_SUM,   // delta from sum, new weight
    OP_LOAD       // write weight, clear delta
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       mac_en;  // add into accumulator; the forward MAC is gated by index range
  } dp_cmd_t;

  // Unsigned quotient by shift and subtract, used only while building tables.
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Table entry i: tanh(8i/size) rounded to Q4.12, built at elaboration.
  function automatic logic [12:0] tanh_entry(input int unsigned i, input int unsigned size);
    longint unsigned yq, ipart, frac, mag, em, num, den;
    longint signed e;
    yq = udiv64(longint'(i) << 34, 64'(size));
    ipart = yq >> 30;
    frac = yq & ((64'd1 << 30) - 1);
    mag = 64'd1 << 30;
    e = 64'sd1 << 30;
    for (int k = 1; k <= 20; k++) begin
      mag = udiv64((mag * frac) >> 30, 64'(k));
      if (k[0]) e = e - longint'(mag);
      else e = e + longint'(mag);
    end
    em = longint'(e);
    for (longint unsigned k = 0; k < ipart; k++) begin
      em = (em * 64'd395007542) >> 30;
    end
    num = (64'd1 << 30) - em;
    den = (64'd1 << 30) + em;
    return 13'(udiv64(num * 4096 + (den >> 1), den));
  endfunction

endpackage

[hdl/nmtb_ram.sv]
// ----------------------------------------------------------------------------
// nmtb_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nmtb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

[hdl/nmtb_ctrl.sv]
// ----------------------------------------------------------------------------
// nmtb_ctrl
// Sequencer: accepts one item, steps the datapath, hands off the result.
// ----------------------------------------------------------------------------
module nmtb_ctrl
  import nmtb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic [2:0] in_mode,
  input  logic      in_last,
  input  logic      idx_ok,
  input  logic      clr_busy,
  output logic      in_ready,
  output logic      take,
  output dp_cmd_t   cmd,
  output logic      res_load,
  input  logic      res_free
);
  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_FWD, S_FWDE, S_HMAC, S_HD, S_HM, S_HF, S_OD, S_OM,
    S_U1, S_U2, S_U3, S_LD
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;

  assign in_ready = (state_r == S_IDLE) && !clr_busy;
  assign take     = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cmd       = '{op: OP_NONE, mac_en: 1'b0};
    res_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          last_nxt = in_last;
          case (in_mode)
            MODE_FWD:  state_nxt = S_FWD;
            MODE_OGRD: state_nxt = S_OD;
            MODE_HGRD: state_nxt = S_HMAC;
            MODE_UPD:  state_nxt = idx_ok ? S_U1 : S_IDLE;
            MODE_LOAD: state_nxt = idx_ok ? S_LD : S_IDLE;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_FWD: begin
        cmd = '{op: OP_FWD_MAC, mac_en: 1'b1};
        state_nxt = last_r ? S_FWDE : S_IDLE;
      end
      S_FWDE: if (res_free) begin
        cmd = '{op: OP_FWD_END, mac_en: 1'b0};
        res_load = 1'b1;
        state_nxt = S_IDLE;
      end
      S_HMAC: begin
        cmd = '{op: OP_HGRD_MAC, mac_en: 1'b1};
        state_nxt = last_r ? S_HD : S_IDLE;
      end
      S_HD: begin
        cmd = '{op: OP_DERIV, mac_en: 1'b0};
        state_nxt = S_HM;
      end
      S_HM: begin
        cmd = '{op: OP_HGRD_MUL, mac_en: 1'b0};
        state_nxt = S_HF;
      end
      S_HF: if (res_free) begin
        cmd = '{op: OP_HGRD_FIN, mac_en: 1'b0};
        res_load = 1'b1;
        state_nxt = S_IDLE;
      end
      S_OD: begin
        cmd = '{op: OP_DERIV, mac_en: 1'b0};
        state_nxt = S_OM;
      end
      S_OM: if (res_free) begin
        cmd = '{op: OP_OGRD_MUL, mac_en: 1'b0};
        res_load = 1'b1;
        state_nxt = S_IDLE;
      end
      S_U1: begin
        cmd = '{op: OP_UPD_P1, mac_en: 1'b0};
        state_nxt = S_U2;
      end
      S_U2: begin
        cmd = '{op: OP_UPD_P2, mac_en: 1'b0};
        state_nxt = S_U3;
      end
      S_U3: if (res_free) begin
        cmd = '{op: OP_UPD_SUM, mac_en: 1'b0};
        res_load = 1'b1;
        state_nxt = S_IDLE;
      end
      S_LD: begin
        cmd = '{op: OP_LOAD, mac_en: 1'b0};
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end
endmodule

[hdl/nmtb_dp.sv]
// ----------------------------------------------------------------------------
// nmtb_dp
// Datapath: weight and delta RAMs, accumulator, multipliers, tanh table and
// the output register.
// ----------------------------------------------------------------------------
module nmtb_dp
  import nmtb_pkg::*;
#(
  parameter int MAX_INPUTS      = 256,
  parameter int TANH_TABLE_SIZE = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [7:0]         in_idx,
  input  logic signed [15:0] in_val,
  input  logic signed [15:0] in_ow,
  input  dp_cmd_t            cmd,
  input  logic               res_load,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [14:0]        cfg_data,
  output logic               idx_ok,
  output logic               clr_busy,
  output logic               res_free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_idx,
  output logic signed [15:0] out_res,
  output logic               out_sat
);
  localparam int AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int TW = $clog2(TANH_TABLE_SIZE);
  localparam int CW = AW + 1;

  typedef logic [12:0] tab_t [TANH_TABLE_SIZE];
  function automatic logic [12:0] build_tab_e(int i);
    return tanh_entry(i, TANH_TABLE_SIZE);
  endfunction
  function automatic tab_t build_tab();
    tab_t t;
    for (int i = 0; i < TANH_TABLE_SIZE; i++) t[i] = build_tab_e(i);
    return t;
  endfunction
  localparam tab_t TANH_TAB = build_tab();

  logic [12:0] eta_r;
  logic [14:0] alpha_r;
  logic [7:0]  idx_r;
  logic signed [15:0] val_r, ow_r;
  logic signed [31:0] acc_r;
  logic signed [15:0] nout_r, ngrad_r;
  logic signed [16:0] deriv_r;
  logic signed [47:0] hprod_r;
  logic signed [29:0] p1_r;
  logic signed [46:0] pa_r, pb_r;
  logic               ok_r;
  logic [CW-1:0]      clr_cnt_r;

  // Clearing pass over both RAMs after reset.
  assign clr_busy = clr_cnt_r < CW'(MAX_INPUTS);
  assign idx_ok = {24'b0, in_idx} < 32'(MAX_INPUTS);

  logic            w_we, d_we;
  logic [AW-1:0]   w_wa;
  logic [AW-1:0]   r_addr;
  logic [15:0]     w_wd, d_wd, w_rd, d_rd;

  // The accepted index is read at the accepting edge, then held from idx_r.
  assign r_addr = take ? AW'(in_idx) : AW'(idx_r);

  nmtb_ram #(.WIDTH(16), .DEPTH(MAX_INPUTS)) u_wram (
    .clk(clk), .wr_en(w_we), .wr_addr(w_wa), .wr_data(w_wd),
    .rd_addr(r_addr), .rd_data(w_rd));
  nmtb_ram #(.WIDTH(16), .DEPTH(MAX_INPUTS)) u_dram (
    .clk(clk), .wr_en(d_we), .wr_addr(w_wa), .wr_data(d_wd),
    .rd_addr(r_addr), .rd_data(d_rd));

  // Combinational helpers.
  logic signed [32:0] macsum;
  logic signed [31:0] mprod, acc_sat;
  logic signed [31:0] sx;
  logic [31:0]        ax;
  logic [15:0]        axc;
  logic [TW-1:0]      ti;
  logic signed [15:0] tv;
  logic signed [16:0] dif;
  logic signed [33:0] og;
  logic signed [21:0] ogs;
  logic signed [47:0] pfull;
  logic signed [23:0] hgs;
  logic signed [47:0] usum;
  logic signed [23:0] dlt;
  logic signed [15:0] dsat;
  logic signed [16:0] nw;
  logic               dsf;
  logic signed [31:0] sq;
  logic signed [31:0] ad_prod;

  always_comb begin
    mprod  = (cmd.op == OP_FWD_MAC) ? val_r * $signed(w_rd) : ow_r * val_r;
    if (cmd.op == OP_FWD_MAC && !ok_r) mprod = '0;
    macsum = 33'(acc_r) + 33'(mprod);
    if (macsum > 33'sh07FFFFFFF) acc_sat = 32'sh7FFFFFFF;
    else if (macsum < -33'sh080000000) acc_sat = 32'sh80000000;
    else acc_sat = macsum[31:0];
    sx  = acc_r >>> 12;
    ax  = sx[31] ? 32'(-sx) : 32'(sx);
    axc = (ax > 32'd32767) ? 16'd32767 : ax[15:0];
    ti  = TW'((32'(axc) * TANH_TABLE_SIZE) >> 15);
    tv  = sx[31] ? -$signed({3'b0, TANH_TAB[ti]}) : $signed({3'b0, TANH_TAB[ti]});
    sq  = nout_r * nout_r;
    dif = 17'(val_r) - 17'(nout_r);
    og  = dif * deriv_r;
    ogs = og[33:12];
    pfull = hprod_r;
    hgs = pfull[47:24];
    ad_prod = $signed({1'b0, alpha_r}) * $signed(d_rd);
    usum = 48'(pa_r) + 48'(pb_r);
    dlt = usum[47:24];
    dsf = (dlt > 24'sd32767) || (dlt < -24'sd32768);
    dsat = (dlt > 24'sd32767) ? 16'sh7FFF : (dlt < -24'sd32768) ? 16'sh8000 : dlt[15:0];
    nw  = 17'($signed(w_rd)) + 17'(dsat);
  end

  always_comb begin
    w_we = 1'b0; d_we = 1'b0;
    w_wa = AW'(idx_r); w_wd = val_r; d_wd = '0;
    if (clr_busy) begin
      w_we = 1'b1; d_we = 1'b1; w_wa = clr_cnt_r[AW-1:0]; w_wd = '0;
    end else if (cmd.op == OP_LOAD) begin
      w_we = 1'b1; d_we = 1'b1;
    end else if (cmd.op == OP_UPD_SUM) begin
      w_we = 1'b1; d_we = 1'b1; d_wd = dsat;
      w_wd = (nw > 17'sd32767) ? 16'sh7FFF : (nw < -17'sd32768) ? 16'sh8000 : nw[15:0];
    end
  end

  assign res_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eta_r <= 13'd614; alpha_r <= 15'd2048;
      acc_r <= '0; nout_r <= '0; ngrad_r <= '0;
      clr_cnt_r <= '0; out_valid <= 1'b0;
    end else begin
      if (clr_busy) clr_cnt_r <= clr_cnt_r + CW'(1);
      if (cfg_we && cfg_addr == CFG_LEARN_RATE) eta_r <= cfg_data[12:0];
      if (cfg_we && cfg_addr == CFG_MOMENTUM) alpha_r <= cfg_data;
      if (take) begin
        idx_r <= in_idx; val_r <= in_val; ow_r <= in_ow; ok_r <= idx_ok;
      end
      if (cmd.mac_en) acc_r <= acc_sat;
      if (res_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (cmd.op)
        OP_FWD_END: begin
          nout_r <= tv; acc_r <= '0;
          out_kind <= KIND_OUT; out_idx <= '0; out_res <= tv; out_sat <= 1'b0;
        end
        OP_DERIV: deriv_r <= 17'sd4096 - 17'(sq >>> 12);
        OP_OGRD_MUL: begin
          out_kind <= KIND_GRAD; out_idx <= '0;
          if (ogs > 22'sd32767) begin
            out_res <= 16'sh7FFF; ngrad_r <= 16'sh7FFF; out_sat <= 1'b1;
          end else if (ogs < -22'sd32768) begin
            out_res <= 16'sh8000; ngrad_r <= 16'sh8000; out_sat <= 1'b1;
          end else begin
            out_res <= ogs[15:0]; ngrad_r <= ogs[15:0]; out_sat <= 1'b0;
          end
        end
        OP_HGRD_MUL: hprod_r <= acc_r * deriv_r;
        OP_HGRD_FIN: begin
          acc_r <= '0; out_kind <= KIND_GRAD; out_idx <= '0;
          if (hgs > 24'sd32767) begin
            out_res <= 16'sh7FFF; ngrad_r <= 16'sh7FFF; out_sat <= 1'b1;
          end else if (hgs < -24'sd32768) begin
            out_res <= 16'sh8000; ngrad_r <= 16'sh8000; out_sat <= 1'b1;
          end else begin
            out_res <= hgs[15:0]; ngrad_r <= hgs[15:0]; out_sat <= 1'b0;
          end
        end
        OP_UPD_P1: p1_r <= $signed({1'b0, eta_r}) * val_r;
        OP_UPD_P2: begin
          pa_r <= p1_r * ngrad_r;
          pb_r <= 47'(ad_prod) <<< 12;
        end
        OP_UPD_SUM: begin
          out_kind <= KIND_WGT; out_idx <= idx_r; out_res <= w_wd;
          out_sat <= dsf || (nw > 17'sd32767) || (nw < -17'sd32768);
        end
        default: ;
      endcase
    end
  end
endmodule

[hdl/neuron_mac_tanh_backprop.sv]
// ----------------------------------------------------------------------------
// neuron_mac_tanh_backprop
// Single tanh neuron with backprop training and momentum, Q4.12 fixed point.
// ----------------------------------------------------------------------------
// Channel | Dir | tdata (low bit up)                       | tuser
// in_     | in  | conn_index[7:0], value[15:0], out_weight | mode[2:0]; tlast = last
// out_    | out | res_index[7:0], result[15:0]             | kind[1:0], saturated
// cfg_    | in  | index 0 learn_rate, 1 momentum           | -
// Each item runs the controller sequence for its mode; a result step waits
// while the output register still holds an unaccepted result.
// After reset a clearing pass over all MAX_INPUTS entries zeroes both RAMs.
// The output register lets the next item enter while a result waits.
module neuron_mac_tanh_backprop
  import nmtb_pkg::*;
#(
  parameter int MAX_INPUTS      = 256,
  parameter int TANH_TABLE_SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // conn_index, value, out_weight
  input  logic [2:0]  in_tuser,   // mode
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // res_index, result
  output logic [2:0]  out_tuser,  // kind, saturated
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [14:0] cfg_data
);
  dp_cmd_t cmd;
  logic idx_ok, clr_busy, take, res_load, res_free;
  logic [1:0] kind;
  logic [7:0] ridx;
  logic signed [15:0] res;
  logic sat;

  nmtb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_mode(in_tuser),
    .in_last(in_tlast), .idx_ok(idx_ok), .clr_busy(clr_busy),
    .in_ready(in_tready), .take(take), .cmd(cmd), .res_load(res_load),
    .res_free(res_free));

  nmtb_dp #(.MAX_INPUTS(MAX_INPUTS), .TANH_TABLE_SIZE(TANH_TABLE_SIZE)) u_dp (
    .clk(clk), .rst_n(rst_n), .take(take), .in_idx(in_tdata[7:0]),
    .in_val(in_tdata[23:8]), .in_ow(in_tdata[39:24]), .cmd(cmd),
    .res_load(res_load), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_data(cfg_data), .idx_ok(idx_ok), .clr_busy(clr_busy),
    .res_free(res_free), .out_valid(out_tvalid), .out_ready(out_tready),
    .out_kind(kind), .out_idx(ridx), .out_res(res), .out_sat(sat));

  assign out_tdata = {res, ridx};
  assign out_tuser = {sat, kind};
endmodule
